// ----- hw/rtl/lsf_pkg.sv -----
// Shared types, constants and register codes for the sweeping fade dither block.
// No dependencies; the core modules and the testbench import this package.
`timescale 1ns / 1ps

package lsf_pkg;

  localparam int SLOTS  = 128;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Bit-serial divider sizes.
  localparam int DIV_BITS_W = 20;
  localparam int DIV_DEN_W  = 16;
  localparam int DIV_CNT_W  = 5;
  localparam logic [DIV_CNT_W-1:0] HEAD_DIV_STEPS = 5'd17;
  localparam logic [DIV_CNT_W-1:0] FADE_DIV_STEPS = 5'd20;

  typedef enum logic [2:0] {
    CFG_MAX_LEVEL    = 3'd0,
    CFG_SWEEP_MS     = 3'd1,
    CFG_PAUSE_MS     = 3'd2,
    CFG_HALF_WIDTH   = 3'd3,
    CFG_BASE_LENGTH  = 3'd4,
    CFG_SPAWN_OFFSET = 3'd5
  } cfg_idx_t;

  localparam logic [7:0]  RST_MAX_LEVEL    = 8'd24;
  localparam logic [15:0] RST_SWEEP_MS     = 16'd10000;
  localparam logic [15:0] RST_PAUSE_MS     = 16'd2000;
  localparam logic [3:0]  RST_HALF_WIDTH   = 4'd2;
  localparam logic [7:0]  RST_BASE_LENGTH  = 8'd37;
  localparam logic [7:0]  RST_SPAWN_OFFSET = 8'd8;

  typedef struct packed {
    logic [7:0]  max_level;
    logic [15:0] sweep_len;
    logic [15:0] rest_len;
    logic [3:0]  fade_hw;
    logic [7:0]  base_length;
    logic [7:0]  spawn_offset;
  } cfg_t;

  // One classified pixel request, as the front hands it to the back.
  typedef struct packed {
    logic        in_sweep;
    logic [15:0] t;
    logic [6:0]  slot;
    logic [7:0]  position;
    logic        use_spawn;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_DEN_W-1:0]  rem_init;
    logic [DIV_BITS_W-1:0] bits;
    logic [DIV_DEN_W-1:0]  den;
    logic [DIV_CNT_W-1:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic [DIV_BITS_W-1:0] quo;
  } div_rsp_t;

  function automatic logic [SLOT_W-1:0] slot_index(input logic [6:0] slot);
    return SLOT_W'(32'(slot) % SLOTS);
  endfunction

endpackage

// ----- hw/rtl/lsf_in_if.sv -----
// Pixel request channel: valid/ready handshake and the request payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface lsf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [6:0]  slot;
  logic [7:0]  position;
  logic        use_spawn;

  modport source (output valid, now_ms, slot, position, use_spawn, input ready);
  modport sink   (input valid, now_ms, slot, position, use_spawn, output ready);
endinterface

// ----- hw/rtl/lsf_out_if.sv -----
// Level result channel: valid/ready handshake and the result payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface lsf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] slot_out;
  logic [7:0] level;

  modport source (output valid, slot_out, level, input ready);
  modport sink   (input valid, slot_out, level, output ready);
endinterface

// ----- hw/rtl/lsf_front.sv -----
// Front end: accepts pixel requests, keeps the cycle start time and classifies
// each request as sweep or pause. Depends on lsf_pkg and lsf_in_if.
`timescale 1ns / 1ps

module lsf_front import lsf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  lsf_in_if.sink   req,
  input  q_stat_t  q_stat,
  output logic     push,
  output q_entry_t entry
);

  logic        started;
  logic [31:0] period_origin;
  logic [31:0] base;
  logic [31:0] elapsed;
  logic [16:0] limit;
  logic        restart;
  logic [31:0] t_eff;

  always_comb begin
    base    = started ? period_origin : req.now_ms;
    elapsed = req.now_ms - base;
    limit   = {1'b0, cfg.sweep_len} + {1'b0, cfg.rest_len};
    restart = elapsed > {15'd0, limit};
    t_eff   = restart ? 32'd0 : elapsed;

    entry.in_sweep  = t_eff < {16'd0, cfg.sweep_len};
    entry.t         = t_eff[15:0];
    entry.slot      = req.slot;
    entry.position  = req.position;
    entry.use_spawn = req.use_spawn;
  end

  assign req.ready = !q_stat.full;
  assign push      = req.valid && !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      period_origin <= '0;
    end else if (push) begin
      started <= 1'b1;
      if (!started || restart) begin
        period_origin <= req.now_ms;
      end
    end
  end

endmodule

// ----- hw/rtl/lsf_queue.sv -----
// Short FIFO of classified requests between the front and the back.
// Depends on lsf_pkg.
`timescale 1ns / 1ps

module lsf_queue import lsf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t din,
  input  logic     pop,
  output q_entry_t dout,
  output q_stat_t  stat
);

  q_entry_t                entries [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [$clog2(QDEPTH+1)-1:0] count;

  assign stat.full  = count == ($clog2(QDEPTH+1))'(QDEPTH);
  assign stat.empty = count == '0;
  assign dout       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/lsf_div.sv -----
// Restoring divider that retires one quotient bit per cycle, shared by the
// head position and fade level divisions. Depends on lsf_pkg.
`timescale 1ns / 1ps

module lsf_div import lsf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t dreq,
  output div_rsp_t drsp
);

  logic [DIV_DEN_W-1:0]  rem;
  logic [DIV_BITS_W-1:0] bits;
  logic [DIV_DEN_W-1:0]  den;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIV_BITS_W-1:0] quo;
  logic                  busy;
  logic [DIV_DEN_W:0]    trial;
  logic                  ge;
  logic [DIV_DEN_W:0]    rem_next;

  always_comb begin
    trial    = {rem, bits[DIV_BITS_W-1]};
    ge       = trial >= {1'b0, den};
    rem_next = ge ? trial - {1'b0, den} : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (dreq.start) begin
      busy <= 1'b1;
      cnt  <= dreq.steps;
      rem  <= dreq.rem_init;
      bits <= dreq.bits;
      den  <= dreq.den;
      quo  <= '0;
    end else if (busy) begin
      rem  <= rem_next[DIV_DEN_W-1:0];
      bits <= {bits[DIV_BITS_W-2:0], 1'b0};
      quo  <= {quo[DIV_BITS_W-2:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign drsp.busy = busy;
  assign drsp.quo  = quo;

endmodule

// ----- hw/rtl/lsf_back.sv -----
// Back end: head position, triangular fade and delta-sigma stage for one
// request at a time, with the remainder memory and the result register.
// Depends on lsf_pkg, lsf_out_if and the shared divider.
`timescale 1ns / 1ps

module lsf_back import lsf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  q_entry_t q_dout,
  input  q_stat_t  q_stat,
  output logic     pop,
  output div_req_t dreq,
  input  div_rsp_t drsp,
  lsf_out_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV1,
    S_FADE,
    S_HIT,
    S_DIV2,
    S_EMIT
  } state_t;

  state_t            state;
  q_entry_t          cur;
  logic [SLOT_W-1:0] cur_idx;
  logic [SLOT_W-1:0] pop_idx;
  logic [18:0]       sep;
  logic [15:0]       target;
  logic [7:0]        rem_rd;
  logic              out_valid;
  logic [6:0]        out_slot;
  logic [7:0]        out_level;

  logic [7:0]        rem_mem [SLOTS];
  logic [SLOTS-1:0]  rem_vld;

  logic [8:0]        travel;
  logic [24:0]       prod;
  logic [32:0]       num1;
  logic [8:0]        rest_pos;
  logic signed [19:0] head;
  logic signed [19:0] head_sp;
  logic signed [19:0] diff;
  logic [11:0]       span;
  logic              hit;
  logic [11:0]       closeness;
  logic [19:0]       num2;
  logic [15:0]       acc;
  logic              out_free;
  logic              mem_wr;

  always_comb begin
    pop     = (state == S_IDLE) && !q_stat.empty;
    pop_idx = slot_index(q_dout.slot);

    travel = {1'b0, cfg.base_length} + {4'd0, cfg.fade_hw, 1'b0};
    prod   = {16'd0, travel} * {9'd0, cur.t};
    num1   = {prod, 8'd0};

    // Head position in Q8 LED units.
    rest_pos = {1'b0, cfg.base_length} + {5'd0, cfg.fade_hw};
    if (cur.in_sweep) begin
      head = $signed({3'd0, drsp.quo[16:0]}) - $signed({8'd0, cfg.fade_hw, 8'd0});
    end else begin
      head = $signed({3'd0, rest_pos, 8'd0});
    end
    head_sp = cur.use_spawn ? head - $signed({4'd0, cfg.spawn_offset, 8'd0}) : head;
    diff    = head_sp - $signed({4'd0, cur.position, 8'd0});

    span      = {cfg.fade_hw, 8'd0};
    hit       = (cfg.fade_hw != 4'd0) && (sep < {7'd0, span});
    closeness = span - sep[11:0];
    num2      = {12'd0, cfg.max_level} * {8'd0, closeness};

    dreq = '0;
    if (state == S_MUL && cur.in_sweep) begin
      dreq.start    = 1'b1;
      dreq.rem_init = num1[32:17];
      dreq.bits     = {num1[16:0], 3'd0};
      dreq.den      = cfg.sweep_len;
      dreq.steps    = HEAD_DIV_STEPS;
    end else if (state == S_HIT && hit) begin
      dreq.start    = 1'b1;
      dreq.rem_init = '0;
      dreq.bits     = num2;
      dreq.den      = {12'd0, cfg.fade_hw};
      dreq.steps    = FADE_DIV_STEPS;
    end

    acc      = {8'd0, rem_rd} + target;
    out_free = !out_valid || rsp.ready;
    mem_wr   = (state == S_EMIT) && out_free;
  end

  // Remainder memory; an entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      rem_mem[cur_idx] <= acc[7:0];
    end
    if (pop) begin
      rem_rd <= rem_vld[pop_idx] ? rem_mem[pop_idx] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rem_vld   <= '0;
    end else begin
      if (mem_wr) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            cur     <= q_dout;
            cur_idx <= pop_idx;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          state <= cur.in_sweep ? S_DIV1 : S_FADE;
        end
        S_DIV1: begin
          if (!drsp.busy) begin
            state <= S_FADE;
          end
        end
        S_FADE: begin
          sep   <= diff[19] ? 19'(-diff) : diff[18:0];
          state <= S_HIT;
        end
        S_HIT: begin
          if (hit) begin
            state <= S_DIV2;
          end else begin
            target <= '0;
            state  <= S_EMIT;
          end
        end
        S_DIV2: begin
          if (!drsp.busy) begin
            target <= drsp.quo[15:0];
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_slot         <= cur.slot;
            out_level        <= acc[15:8];
            rem_vld[cur_idx] <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.slot_out = out_slot;
  assign rsp.level    = out_level;

endmodule

// ----- hw/rtl/led_sweep_fade_dither.sv -----
// Sweeping head fade with per-slot first-order delta-sigma dither.
// The time from request beat to result beat is set by the bit-serial divisions
// (17 and 20 steps): head position in the sweep, fade level inside the fade.
// The back end works on one request at a time while two queue entries let the
// front take requests. Synchronous active-high reset restores the register
// defaults, zeroes all remainders and clears the cycle start.
`timescale 1ns / 1ps

module led_sweep_fade_dither import lsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lsf_in_if.sink      req,
  lsf_out_if.source   rsp,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t     cfg;
  logic     push;
  logic     pop;
  q_entry_t q_din;
  q_entry_t q_dout;
  q_stat_t  q_stat;
  div_req_t dreq;
  div_rsp_t drsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_level    <= RST_MAX_LEVEL;
      cfg.sweep_len    <= RST_SWEEP_MS;
      cfg.rest_len     <= RST_PAUSE_MS;
      cfg.fade_hw      <= RST_HALF_WIDTH;
      cfg.base_length  <= RST_BASE_LENGTH;
      cfg.spawn_offset <= RST_SPAWN_OFFSET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_LEVEL:    cfg.max_level    <= cfg_data[7:0];
        CFG_SWEEP_MS:     cfg.sweep_len    <= cfg_data;
        CFG_PAUSE_MS:     cfg.rest_len     <= cfg_data;
        CFG_HALF_WIDTH:   cfg.fade_hw      <= cfg_data[3:0];
        CFG_BASE_LENGTH:  cfg.base_length  <= cfg_data[7:0];
        CFG_SPAWN_OFFSET: cfg.spawn_offset <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  lsf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .req    (req),
    .q_stat (q_stat),
    .push   (push),
    .entry  (q_din)
  );

  lsf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (q_din),
    .pop  (pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  lsf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .dreq (dreq),
    .drsp (drsp)
  );

  lsf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_dout (q_dout),
    .q_stat (q_stat),
    .pop    (pop),
    .dreq   (dreq),
    .drsp   (drsp),
    .rsp    (rsp)
  );

endmodule

// ----- hw/rtl/lsf_checker.sv -----
// Port-level checks for led_sweep_fade_dither, attached by the bind below.
// Depends on the top level's request and result channels.
`timescale 1ns / 1ps

module lsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [6:0] slot_out,
  input logic [7:0] level
);

  // Queue entries, the item in the back end and the result register.
  localparam logic [2:0] CAPACITY = 3'd4;

  logic       req_beat;
  logic       rsp_beat;
  logic [2:0] pending;

  assign req_beat = req_valid && req_ready;
  assign rsp_beat = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_beat && !rsp_beat) begin
      pending <= pending + 1'b1;
    end else if (rsp_beat && !req_beat) begin
      pending <= pending - 1'b1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(slot_out) && $stable(level))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    rsp_beat |-> pending != 3'd0)
    else $error("result beat without an outstanding request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending == CAPACITY |-> !req_ready)
    else $error("request taken with every buffer occupied");

endmodule

bind led_sweep_fade_dither lsf_checker u_lsf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .slot_out  (rsp.slot_out),
  .level     (rsp.level)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for led_sweep_fade_dither: a scoreboard class predicts each
// dithered level from the pixel requests it sees accepted. Depends on lsf_pkg,
// lsf_in_if, lsf_out_if and the block itself.
`timescale 1ns / 1ps

class fade_scoreboard;
  typedef struct packed {
    logic [6:0] slot;
    logic [7:0] level;
  } level_beat_t;

  logic [7:0]  max_level;
  logic [15:0] sweep_len;
  logic [15:0] rest_len;
  logic [3:0]  fade_hw;
  logic [7:0]  base_length;
  logic [7:0]  spawn_offset;

  logic [7:0]  remainders [lsf_pkg::SLOTS];
  logic [31:0] period_origin;
  logic        started;

  level_beat_t expected_levels [$];
  int          errors;
  int          requests;
  int          results;
  int          lit;

  function new();
    max_level    = lsf_pkg::RST_MAX_LEVEL;
    sweep_len    = lsf_pkg::RST_SWEEP_MS;
    rest_len     = lsf_pkg::RST_PAUSE_MS;
    fade_hw      = lsf_pkg::RST_HALF_WIDTH;
    base_length  = lsf_pkg::RST_BASE_LENGTH;
    spawn_offset = lsf_pkg::RST_SPAWN_OFFSET;
    foreach (remainders[i]) remainders[i] = 8'd0;
    period_origin = 32'd0;
    started       = 1'b0;
    errors      = 0;
    requests    = 0;
    results     = 0;
    lit         = 0;
  endfunction

  function void set_reg(lsf_pkg::cfg_idx_t idx, logic [15:0] value);
    case (idx)
      lsf_pkg::CFG_MAX_LEVEL:    max_level    = value[7:0];
      lsf_pkg::CFG_SWEEP_MS:     sweep_len    = value;
      lsf_pkg::CFG_PAUSE_MS:     rest_len     = value;
      lsf_pkg::CFG_HALF_WIDTH:   fade_hw      = value[3:0];
      lsf_pkg::CFG_BASE_LENGTH:  base_length  = value[7:0];
      lsf_pkg::CFG_SPAWN_OFFSET: spawn_offset = value[7:0];
      default: ;
    endcase
  endfunction

  // Head position in Q8 LED units, fade target, then the per-slot delta-sigma step.
  function level_beat_t dither_pixel(logic [31:0] stamp, logic [6:0] slot,
                                     logic [7:0] pos, logic spawn);
    logic [31:0] elapsed;
    logic [63:0] moved;
    longint      head;
    longint      sep;
    longint      span;
    logic [15:0] target;
    logic [16:0] acc;
    int          idx;
    level_beat_t beat;
    if (!started) begin
      started       = 1'b1;
      period_origin = stamp;
    end
    elapsed = stamp - period_origin;
    if (elapsed > 32'(sweep_len) + 32'(rest_len)) begin
      period_origin = stamp;
      elapsed       = 32'd0;
    end
    if (elapsed < 32'(sweep_len)) begin
      moved = (64'(base_length) + 2 * 64'(fade_hw)) * 256 * 64'(elapsed) / 64'(sweep_len);
      head  = -longint'(fade_hw) * 256 + longint'(moved);
    end else begin
      head = (longint'(base_length) + longint'(fade_hw)) * 256;
    end
    if (spawn) head -= longint'(spawn_offset) * 256;
    sep = head - longint'(pos) * 256;
    if (sep < 0) sep = -sep;
    span = longint'(fade_hw) * 256;
    // A zero half width gives a zero span, so no pixel is ever lit and no division runs.
    if (sep >= span) target = 16'd0;
    else target = 16'((longint'(max_level) * (span - sep)) / longint'(fade_hw));
    idx = int'(slot) % lsf_pkg::SLOTS;
    acc = 17'(remainders[idx]) + 17'(target);
    remainders[idx] = acc[7:0];
    beat.slot  = slot;
    beat.level = acc[15:8];
    return beat;
  endfunction

  function void note_pixel(logic [31:0] stamp, logic [6:0] slot, logic [7:0] pos,
                           logic spawn);
    requests++;
    expected_levels.push_back(dither_pixel(stamp, slot, pos, spawn));
  endfunction

  function void check_level(logic [6:0] slot, logic [7:0] level);
    level_beat_t want;
    results++;
    if (level != 8'd0) lit++;
    if (expected_levels.size() == 0) begin
      errors++;
      $display("%0t: unexpected level beat: expected none, actual slot %0d level %0d",
               $time, slot, level);
      return;
    end
    want = expected_levels.pop_front();
    if (slot !== want.slot) begin
      errors++;
      $display("%0t: slot_out mismatch: expected %0d, actual %0d", $time, want.slot, slot);
    end
    if (level !== want.level) begin
      errors++;
      $display("%0t: level mismatch on slot %0d: expected %0d, actual %0d",
               $time, want.slot, want.level, level);
    end
  endfunction

  function int pending();
    return expected_levels.size();
  endfunction
endclass

module tb_top;
  import lsf_pkg::*;

  typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_CADENCE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  lsf_in_if  req_ch ();
  lsf_out_if rsp_ch ();

  fade_scoreboard sb;
  logic [31:0]    clock_ms;
  int             burst_left;
  int             settings_done;
  bit             hold_rsp;

  led_sweep_fade_dither dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      sb.note_pixel(req_ch.now_ms, req_ch.slot, req_ch.position, req_ch.use_spawn);
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_level(rsp_ch.slot_out, rsp_ch.level);
  end

  // Result side: shifting stall patterns, plus a long hold-off in each squeezed phase.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       held;
    rsp_ch.ready <= 1'b0;
    mode      = RX_STEADY;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        for (held = 0; held < 300; held++) @(posedge clk);
        hold_rsp = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          RX_STEADY:  rsp_ch.ready <= 1'b1;
          RX_LIGHT:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY:   rsp_ch.ready <= ($urandom_range(0, 9) < 3);
          RX_CADENCE: rsp_ch.ready <= (mode_left % 4 != 0);
          default:    rsp_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Offers one beat, waits until it is taken, may then pause; valid stays high within a burst.
  task automatic send_pixel(logic [31:0] stamp, logic [6:0] slot, logic [7:0] pos,
                            logic spawn);
    int gap;
    req_ch.valid     <= 1'b1;
    req_ch.now_ms    <= stamp;
    req_ch.slot      <= slot;
    req_ch.position  <= pos;
    req_ch.use_spawn <= spawn;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap        = $urandom_range(0, 10);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(value);
    sb.set_reg(idx, 16'(value));
    @(posedge clk);
  endtask

  task automatic apply_settings(int peak, int sweep, int pause, int hw, int len, int lag);
    drain();
    put_reg(CFG_MAX_LEVEL, peak);
    put_reg(CFG_SWEEP_MS, sweep);
    put_reg(CFG_PAUSE_MS, pause);
    put_reg(CFG_HALF_WIDTH, hw);
    put_reg(CFG_BASE_LENGTH, len);
    put_reg(CFG_SPAWN_OFFSET, lag);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // Picks a position within a few LEDs of where the head should be, so most pixels light.
  function automatic logic [7:0] aim_position(logic [31:0] stamp, logic spawn);
    logic [31:0] elapsed;
    longint      hw;
    longint      spot;
    hw      = longint'(sb.fade_hw);
    elapsed = stamp - sb.period_origin;
    if (longint'(elapsed) > longint'(sb.sweep_len) + longint'(sb.rest_len)) elapsed = 32'd0;
    if (elapsed < 32'(sb.sweep_len))
      spot = -hw + (longint'(sb.base_length) + 2 * hw) * longint'(elapsed)
             / longint'(sb.sweep_len);
    else
      spot = longint'(sb.base_length) + hw;
    if (spawn) spot -= longint'(sb.spawn_offset);
    spot += longint'($urandom_range(0, 2 * hw + 2)) - hw - 1;
    if (spot < 0) spot = 0;
    if (spot > 255) spot = 255;
    return 8'(spot);
  endfunction

  // Frames of pixels sharing one time stamp; time mostly moves forward in small steps.
  task automatic sweep_phase(int count, bit squeeze, bit pause_mid);
    int         left;
    int         kind;
    int         frame;
    int         cycle_len;
    logic       spawn;
    logic [6:0] slot;
    logic [7:0] pos;
    left      = count;
    cycle_len = int'(sb.sweep_len) + int'(sb.rest_len);
    if (squeeze) hold_rsp = 1'b1;
    while (left > 0) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) clock_ms = clock_ms - $urandom_range(1, 5000);
      else if (kind < 9) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, cycle_len / 20 + 1);
      frame = $urandom_range(1, 10);
      while (frame > 0 && left > 0) begin
        spawn = ($urandom_range(0, 3) == 0);
        slot  = ($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 7))
                                            : 7'($urandom_range(0, 127));
        if ($urandom_range(0, 9) == 0) begin
          pos   = 8'($urandom_range(0, 255));
          spawn = 1'($urandom_range(0, 1));
        end else begin
          pos = aim_position(clock_ms, spawn);
        end
        send_pixel(clock_ms, slot, pos, spawn);
        frame--;
        left--;
        if (pause_mid && left == count / 2) drain();
      end
    end
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_MAX_LEVEL;
    cfg_data         <= 16'd0;
    req_ch.valid     <= 1'b0;
    req_ch.now_ms    <= 32'd0;
    req_ch.slot      <= 7'd0;
    req_ch.position  <= 8'd0;
    req_ch.use_spawn <= 1'b0;
    sb            = new();
    clock_ms      = 32'd0;
    burst_left    = 1;
    settings_done = 0;
    hold_rsp      = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Power-on settings: the first request loads the cycle start.
    send_pixel(32'd100, 7'd0, 8'd0, 1'b0);
    send_pixel(32'd2600, 7'd1, 8'd8, 1'b0);
    send_pixel(32'd2600, 7'd2, 8'd0, 1'b1);
    send_pixel(32'd10600, 7'd127, 8'd39, 1'b0);
    send_pixel(32'd10600, 7'd127, 8'd38, 1'b0);
    send_pixel(32'd10600, 7'd127, 8'd39, 1'b1);
    // Time going backwards or jumping far ahead restarts the cycle; wrapping past the top does not.
    send_pixel(32'd50, 7'd3, 8'd0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 7'd4, 8'd255, 1'b1);
    send_pixel(32'd0, 7'd5, 8'd0, 1'b0);

    // Zero sweep: the head always rests at the end of the path.
    apply_settings(255, 0, 0, 15, 255, 255);
    send_pixel(32'h8000_0000, 7'd6, 8'd255, 1'b0);
    send_pixel(32'h8000_0000, 7'd6, 8'd15, 1'b1);
    send_pixel(32'h8000_0000, 7'd6, 8'd14, 1'b1);
    send_pixel(32'h8000_0000, 7'd7, 8'd255, 1'b0);

    // Zero half width: nothing is ever lit.
    apply_settings(255, 0, 0, 0, 255, 255);
    send_pixel(32'h8000_0000, 7'd6, 8'd15, 1'b1);
    send_pixel(32'h8000_0001, 7'd8, 8'd0, 1'b0);

    // Slowest sweep with a fractional fade, so the remainder carries between frames.
    apply_settings(7, 65535, 65535, 1, 1, 0);
    send_pixel(32'h8000_0010, 7'd9, 8'd0, 1'b0);
    send_pixel(32'h8000_7530, 7'd9, 8'd0, 1'b0);
    send_pixel(32'h8000_7530, 7'd9, 8'd0, 1'b0);
    send_pixel(32'h8000_7530, 7'd9, 8'd0, 1'b0);
    send_pixel(32'h8001_87A0, 7'd10, 8'd2, 1'b0);
    send_pixel(32'h8001_87A0, 7'd11, 8'd1, 1'b1);
    clock_ms = 32'h8001_87A0;

    apply_settings(24, 10000, 2000, 2, 37, 8);
    sweep_phase(205, 1'b1, 1'b0);
    apply_settings(255, 1, 0, 15, 200, 0);
    sweep_phase(205, 1'b0, 1'b0);
    apply_settings(255, 65535, 65535, 1, 1, 255);
    sweep_phase(205, 1'b0, 1'b1);
    apply_settings(0, 300, 100, 8, 128, 40);
    sweep_phase(205, 1'b0, 1'b0);
    apply_settings($urandom_range(0, 255), $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 255));
    sweep_phase(205, 1'b0, 1'b0);
    apply_settings(200, 0, 50, 6, 60, 20);
    sweep_phase(205, 1'b0, 1'b0);
    apply_settings($urandom_range(1, 255), $urandom_range(16, 4000), $urandom_range(0, 3000),
                   $urandom_range(1, 15), $urandom_range(1, 255), $urandom_range(0, 255));
    sweep_phase(205, 1'b1, 1'b0);

    drain();
    repeat (60) @(posedge clk);
    $display("Run covered %0d pixel requests under %0d register settings after reset.",
             sb.requests, settings_done);
    $display("Checked %0d level beats, %0d of them nonzero, with %0d mismatches.",
             sb.results, sb.lit, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/lsf_pkg.sv
hw/rtl/lsf_in_if.sv
hw/rtl/lsf_out_if.sv
hw/rtl/lsf_front.sv
hw/rtl/lsf_queue.sv
hw/rtl/lsf_div.sv
hw/rtl/lsf_back.sv
hw/rtl/led_sweep_fade_dither.sv
hw/rtl/lsf_checker.sv
verif/tb_top.sv
